// ===== rtl/core/cfh_pkg.sv =====
// ----------------------------------------------------------------------------
// cfh_pkg: shared definitions for the crc32c five-tuple flow hash unit
// Holds the crc32c byte step, the l4 mask length table, outcome codes,
// register map and the finalize pipeline payload type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfh_pkg;

  // crc32c, reflected form
  localparam logic [31:0] CrcPoly = 32'h82F6_3B78;

  // default and supported range of stacked vlan tags: 1 to 28
  localparam int unsigned MaxTagsDefault = 4;

  localparam logic [15:0] EtypeIpv4 = 16'h0800;
  localparam logic [15:0] EtypeIpv6 = 16'h86DD;
  localparam logic [6:0]  EthHdrLen = 7'd14;
  localparam logic [7:0]  VerMask   = 8'hf0;
  localparam logic [7:0]  VerIpv4   = 8'h40;
  localparam logic [7:0]  VerIpv6   = 8'h60;

  // ip protocol numbers that keep l4 bytes
  localparam logic [7:0] ProtoIcmp   = 8'd1;
  localparam logic [7:0] ProtoIgmp   = 8'd2;
  localparam logic [7:0] ProtoTcp    = 8'd6;
  localparam logic [7:0] ProtoUdp    = 8'd17;
  localparam logic [7:0] ProtoEsp    = 8'd50;
  localparam logic [7:0] ProtoAh     = 8'd51;
  localparam logic [7:0] ProtoIcmpV6 = 8'd58;

  // register indexes on the config port
  localparam logic [1:0] RegEntryMode = 2'd0;
  localparam logic [1:0] RegTagFirst  = 2'd1;
  localparam logic [1:0] RegTagSecond = 2'd2;

  localparam logic [15:0] TagFirstReset  = 16'h8100;
  localparam logic [15:0] TagSecondReset = 16'h88a8;

  // bytes folded in after the addresses: 4 l4, protocol, 3 zero
  localparam int unsigned FinBytes = 8;

  typedef enum logic [1:0] {
    OUT_HASHED    = 2'd0,
    OUT_NOT_IP    = 2'd1,
    OUT_TOO_SHORT = 2'd2,
    OUT_MANY_TAGS = 2'd3
  } outcome_e;

  typedef struct packed {
    logic [31:0]           crc;
    logic [8*FinBytes-1:0] data;
    outcome_e              outcome;
  } fin_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ (r[0] ? CrcPoly : 32'h0);
    end
    return r;
  endfunction

  function automatic logic [2:0] mask_len(input logic [7:0] pr);
    logic [2:0] m;
    case (pr)
      ProtoTcp, ProtoUdp, ProtoEsp, ProtoAh: m = 3'd4;
      ProtoIcmp, ProtoIcmpV6:                m = 3'd2;
      ProtoIgmp:                             m = 3'd1;
      default:                               m = 3'd0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crc32c_five_tuple_flow_hash_unit.sv =====
// ----------------------------------------------------------------------------
// crc32c_five_tuple_flow_hash_unit: per-packet five-tuple flow hash
// Parses an ethernet or raw ip byte stream and hashes the addresses, the
// first l4 bytes and the protocol with crc32c.
// ----------------------------------------------------------------------------
// Usage:
//   slave stream: one packet byte per beat in tdata, tuser marks the first
//   byte of a packet, tlast the final byte. A byte arriving with no open
//   packet opens one; tuser in mid packet drops the open packet silently.
//   master stream: one beat per packet, issued for the tlast byte, carrying
//   the flow hash and an outcome code (hash is zero unless hashed).
//   apb port: entry mode at 0x0, first vlan tag type at 0x4, second at 0x8;
//   write only while no packet is in flight.
//   Throughput: one byte per cycle while the master side is not stalled.
//   The tlast byte's result is registered in a capture stage, which is
//   followed by eight stages that fold the bytes after the
//   addresses into the crc, one byte each.
//   When the master side stalls, the whole finalize pipeline and the input
//   hold, and s_axis_tready drops until the result beat is taken.
//   Reset: parser idle, pipeline empty, tag types 0x8100 and 0x88a8,
//   ethernet entry mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crc32c_five_tuple_flow_hash_unit #(
  parameter int unsigned MAX_TAGS = cfh_pkg::MaxTagsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] first_byte
  input  wire logic        s_axis_tlast,   // last_byte
  // master stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [31:0] flow_hash, [33:32] outcome, zero pad
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import cfh_pkg::*;

  localparam int unsigned TagW = $clog2(MAX_TAGS + 1);

  typedef enum logic [2:0] {
    PH_IDLE, PH_ETH, PH_VER, PH_IP4, PH_IP6, PH_FAIL
  } phase_e;

  // ---------------- configuration registers ----------------
  logic        entry_mode_q;
  logic [15:0] tag_first_q;
  logic [15:0] tag_second_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_mode_q <= 1'b0;
      tag_first_q  <= TagFirstReset;
      tag_second_q <= TagSecondReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegEntryMode: entry_mode_q <= pwdata[0];
        RegTagFirst:  tag_first_q  <= pwdata[15:0];
        RegTagSecond: tag_second_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegEntryMode: prdata = {31'h0, entry_mode_q};
      RegTagFirst:  prdata = {16'h0, tag_first_q};
      RegTagSecond: prdata = {16'h0, tag_second_q};
      default:      prdata = 32'h0;
    endcase
  end

  // ---------------- parser state ----------------
  phase_e            phase_q, phase_c, phase_d;
  logic [7:0]        off_q, off_c;
  logic [31:0]       crc_q, crc_c, crc_d;
  logic [6:0]        ips_q, ips_c, ips_d;
  logic [7:0]        l4s_q, l4s_c, l4s_d;
  logic [7:0]        prot_q, prot_c, prot_d;
  logic [TagW-1:0]   tag_q, tag_c, tag_d;
  logic [7:0]        eth_hi_q, eth_hi_c, eth_hi_d;
  outcome_e          rc_q, rc_c, rc_d;
  logic [31:0]       l4b_q, l4b_c, l4b_d;

  logic              advance;
  logic              beat;
  logic              open_new;
  logic [7:0]        b;
  logic [15:0]       etype;
  logic [7:0]        ips_ext;
  logic [7:0]        rel;
  logic [7:0]        l4_rel;
  logic [2:0]        mlen;
  logic [8:0]        need_l4;
  logic [8:0]        need_ip;
  logic [8:0]        need;
  logic              too_short;
  logic [31:0]       l4_masked;
  fin_t              fin_d;

  assign advance  = !m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = advance;
  assign beat     = s_axis_tvalid & advance;
  assign open_new = s_axis_tuser | (phase_q == PH_IDLE);
  assign b        = s_axis_tdata;

  always_comb begin
    // state as it stands once this byte has opened or advanced the packet
    if (open_new) begin
      off_c    = 8'd0;
      crc_c    = 32'h0;
      tag_c    = '0;
      eth_hi_c = 8'h0;
      prot_c   = 8'h0;
      rc_c     = OUT_HASHED;
      l4s_c    = 8'd0;
      l4b_c    = 32'h0;
      ips_c    = entry_mode_q ? 7'd0 : EthHdrLen;
      phase_c  = entry_mode_q ? PH_VER : PH_ETH;
    end else begin
      off_c    = (off_q == 8'hff) ? off_q : off_q + 8'd1;
      crc_c    = crc_q;
      tag_c    = tag_q;
      eth_hi_c = eth_hi_q;
      prot_c   = prot_q;
      rc_c     = rc_q;
      l4s_c    = l4s_q;
      l4b_c    = l4b_q;
      ips_c    = ips_q;
      phase_c  = phase_q;
    end

    phase_d  = phase_c;
    crc_d    = crc_c;
    tag_d    = tag_c;
    eth_hi_d = eth_hi_c;
    prot_d   = prot_c;
    rc_d     = rc_c;
    l4s_d    = l4s_c;
    l4b_d    = l4b_c;
    ips_d    = ips_c;

    ips_ext = {1'b0, ips_c};
    etype   = {eth_hi_c, b};
    rel     = off_c - ips_ext;
    l4_rel  = 8'd0;

    if (phase_c == PH_ETH) begin
      if (off_c == ips_ext - 8'd2) begin
        eth_hi_d = b;
      end else if (off_c == ips_ext - 8'd1) begin
        if (etype == tag_first_q || etype == tag_second_q) begin
          if (32'(tag_c) >= MAX_TAGS) begin
            phase_d = PH_FAIL;
            rc_d    = OUT_MANY_TAGS;
          end else begin
            tag_d = tag_c + TagW'(1);
            ips_d = ips_c + 7'd4;
          end
        end else if (etype == EtypeIpv4) begin
          phase_d = PH_IP4;
        end else if (etype == EtypeIpv6) begin
          phase_d = PH_IP6;
          l4s_d   = ips_ext + 8'd40;
        end else begin
          phase_d = PH_FAIL;
          rc_d    = OUT_NOT_IP;
        end
      end
    end else begin
      if (phase_c == PH_VER) begin
        if ((b & VerMask) == VerIpv4) begin
          phase_d = PH_IP4;
        end else if ((b & VerMask) == VerIpv6) begin
          phase_d = PH_IP6;
          l4s_d   = ips_ext + 8'd40;
        end else begin
          phase_d = PH_FAIL;
          rc_d    = OUT_NOT_IP;
        end
      end
      if ((phase_d == PH_IP4 || phase_d == PH_IP6) && off_c >= ips_ext) begin
        if (phase_d == PH_IP4) begin
          // ihl in 32-bit words sets the l4 start
          if (rel == 8'd0) l4s_d = ips_ext + {2'b00, b[3:0], 2'b00};
          if (rel == 8'd9) prot_d = b;
          if (rel >= 8'd12 && rel < 8'd20) crc_d = crc_byte(crc_c, b);
        end else begin
          if (rel == 8'd6) prot_d = b;
          if (rel >= 8'd8 && rel < 8'd40) crc_d = crc_byte(crc_c, b);
        end
        l4_rel = off_c - l4s_d;
        if (off_c >= l4s_d && l4_rel < 8'd4) begin
          l4b_d = l4b_c | ({24'h0, b} << {l4_rel[1:0], 3'b000});
        end
      end
    end

    // result decision for the last byte
    mlen    = mask_len(prot_d);
    need_l4 = {1'b0, l4s_d} + {6'h0, mlen};
    need_ip = {2'b00, ips_d} + 9'd20;
    need    = (phase_d == PH_IP4 && need_ip > need_l4) ? need_ip : need_l4;
    too_short = ({1'b0, off_c} + 9'd1) < need;

    for (int i = 0; i < 4; i++) begin
      l4_masked[8*i +: 8] = (3'(i) < mlen) ? l4b_d[8*i +: 8] : 8'h0;
    end

    fin_d.crc     = 32'h0;
    fin_d.data    = '0;
    fin_d.outcome = OUT_TOO_SHORT;
    if (phase_d == PH_FAIL) begin
      fin_d.outcome = rc_d;
    end else if (phase_d == PH_IP4 || phase_d == PH_IP6) begin
      if (!too_short) begin
        fin_d.outcome = OUT_HASHED;
        fin_d.crc     = crc_d;
        fin_d.data    = {24'h0, prot_d, l4_masked};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      off_q    <= 8'd0;
      crc_q    <= 32'h0;
      ips_q    <= 7'd0;
      l4s_q    <= 8'd0;
      prot_q   <= 8'h0;
      tag_q    <= '0;
      eth_hi_q <= 8'h0;
      rc_q     <= OUT_HASHED;
      l4b_q    <= 32'h0;
    end else if (beat) begin
      phase_q  <= s_axis_tlast ? PH_IDLE : phase_d;
      off_q    <= off_c;
      crc_q    <= crc_d;
      ips_q    <= ips_d;
      l4s_q    <= l4s_d;
      prot_q   <= prot_d;
      tag_q    <= tag_d;
      eth_hi_q <= eth_hi_d;
      rc_q     <= rc_d;
      l4b_q    <= l4b_d;
    end
  end

  // ---------------- finalize pipeline, one byte per stage ----------------
  logic [FinBytes:0] fin_vld_q;
  fin_t              fin_q [FinBytes+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= '0;
    end else if (advance) begin
      fin_vld_q <= {fin_vld_q[FinBytes-1:0], beat & s_axis_tlast};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fin_q[0] <= fin_d;
    end
  end

  for (genvar k = 1; k <= FinBytes; k++) begin : g_fin
    always_ff @(posedge clk_i) begin
      if (advance) begin
        fin_q[k].crc     <= crc_byte(fin_q[k-1].crc, fin_q[k-1].data[7:0]);
        fin_q[k].data    <= fin_q[k-1].data >> 8;
        fin_q[k].outcome <= fin_q[k-1].outcome;
      end
    end
  end

  assign m_axis_tvalid = fin_vld_q[FinBytes];
  assign m_axis_tdata  = {6'h0, fin_q[FinBytes].outcome, fin_q[FinBytes].crc};

  // ---------------- assertions ----------------
  a_hash_zero_unless_hashed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[33:32] != OUT_HASHED |-> m_axis_tdata[31:0] == 32'h0)
    else $error("nonzero hash with failing outcome");

  a_last_closes_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && s_axis_tlast |=> phase_q == PH_IDLE && fin_vld_q[0])
    else $error("last byte did not close the packet");

  a_no_result_mid_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && !s_axis_tlast |=> !fin_vld_q[0])
    else $error("result launched without a last byte");

  a_tag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(tag_q) <= MAX_TAGS)
    else $error("tag count beyond limit");

  a_stall_freezes_parser: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(phase_q) && $stable(crc_q) && $stable(off_q))
    else $error("parser moved while stalled");

endmodule

`default_nettype wire

// ===== test/tb_crc32c_five_tuple_flow_hash_unit.sv =====
// ----------------------------------------------------------------------------
// tb_crc32c_five_tuple_flow_hash_unit: stream-level check of the flow hash
// Packet bytes go in one beat at a time. A local parser and crc32c tracker
// predicts each result beat (hash and outcome), and every result beat is
// compared with it. The run covers directed corner packets, then random
// packets under several entry modes and vlan tag settings, with random
// stalls on both streams, apart from the last random phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_crc32c_five_tuple_flow_hash_unit;
  import cfh_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 20;

  typedef enum int {
    PARSE_IDLE, PARSE_ETH, PARSE_VER, PARSE_V4, PARSE_V6, PARSE_DONE
  } parse_e;

  typedef struct packed {
    logic [31:0] hash;
    outcome_e    code;
  } flow_result_t;

  // tracks one packet at a time and queues the result it should produce
  class flow_hash_tracker;
    flow_result_t pending_hashes[$];
    bit           raw_entry;
    logic [15:0]  tag_a, tag_b;
    parse_e       phase;
    int unsigned  offset, ip_base, l4_base, tags;
    logic [7:0]   proto;
    logic [15:0]  etype;
    outcome_e     fail_code;
    logic [31:0]  crc, l4_word;
    int unsigned  beats, errors;
    int unsigned  by_code[4];

    function new();
      raw_entry = 1'b0;
      tag_a     = TagFirstReset;
      tag_b     = TagSecondReset;
      phase     = PARSE_IDLE;
      beats     = 0;
      errors    = 0;
      foreach (by_code[i]) by_code[i] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        RegEntryMode: raw_entry = val[0];
        RegTagFirst:  tag_a = val[15:0];
        RegTagSecond: tag_b = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic fb;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c  = c >> 1;
        if (fb) c = c ^ CrcPoly;
      end
      return c;
    endfunction

    function int unsigned keep_len(logic [7:0] p);
      if (p == ProtoTcp || p == ProtoUdp || p == ProtoEsp || p == ProtoAh) return 4;
      if (p == ProtoIcmp || p == ProtoIcmpV6) return 2;
      if (p == ProtoIgmp) return 1;
      return 0;
    endfunction

    function void open_packet();
      offset    = 0;
      crc       = '0;
      tags      = 0;
      etype     = '0;
      proto     = '0;
      fail_code = OUT_HASHED;
      l4_base   = 0;
      l4_word   = '0;
      if (raw_entry) begin
        ip_base = 0;
        phase   = PARSE_VER;
      end else begin
        ip_base = 14;
        phase   = PARSE_ETH;
      end
    endfunction

    function void parse_byte(logic [7:0] b);
      int unsigned rel;
      if (phase == PARSE_ETH) begin
        if (offset == ip_base - 2) begin
          etype = {b, 8'h00};
        end else if (offset == ip_base - 1) begin
          etype[7:0] = b;
          if (etype == tag_a || etype == tag_b) begin
            if (tags >= MaxTagsDefault) begin
              phase     = PARSE_DONE;
              fail_code = OUT_MANY_TAGS;
            end else begin
              tags++;
              ip_base += 4;
            end
          end else if (etype == EtypeIpv4) begin
            phase = PARSE_V4;
          end else if (etype == EtypeIpv6) begin
            phase   = PARSE_V6;
            l4_base = ip_base + 40;
          end else begin
            phase     = PARSE_DONE;
            fail_code = OUT_NOT_IP;
          end
        end
        return;
      end
      if (phase == PARSE_VER) begin
        if ((b & VerMask) == VerIpv4) begin
          phase = PARSE_V4;
        end else if ((b & VerMask) == VerIpv6) begin
          phase   = PARSE_V6;
          l4_base = ip_base + 40;
        end else begin
          phase     = PARSE_DONE;
          fail_code = OUT_NOT_IP;
          return;
        end
      end
      if ((phase == PARSE_V4 || phase == PARSE_V6) && offset >= ip_base) begin
        rel = offset - ip_base;
        if (phase == PARSE_V4) begin
          if (rel == 0) l4_base = ip_base + 4 * b[3:0];
          if (rel == 9) proto = b;
          if (rel >= 12 && rel < 20) crc = crc_step(crc, b);
        end else begin
          if (rel == 6) proto = b;
          if (rel >= 8 && rel < 40) crc = crc_step(crc, b);
        end
        // small ihl puts the l4 window on top of the ip header
        if (offset >= l4_base && offset - l4_base < 4)
          l4_word = l4_word | (32'(b) << (8 * (offset - l4_base)));
      end
    endfunction

    function void take_beat(logic [7:0] b, bit first, bit last);
      flow_result_t r;
      int unsigned  keep, need;
      logic [31:0]  c;
      beats++;
      if (first || phase == PARSE_IDLE) open_packet();
      else if (offset < 255) offset++;
      parse_byte(b);
      if (!last) return;
      r.hash = '0;
      if (phase == PARSE_DONE) begin
        r.code = fail_code;
      end else if (phase == PARSE_V4 || phase == PARSE_V6) begin
        keep = keep_len(proto);
        need = l4_base + keep;
        if (phase == PARSE_V4 && ip_base + 20 > need) need = ip_base + 20;
        if (offset + 1 < need) begin
          r.code = OUT_TOO_SHORT;
        end else begin
          c = crc;
          for (int i = 0; i < 4; i++) c = crc_step(c, i < keep ? l4_word[8*i +: 8] : 8'h00);
          c = crc_step(c, proto);
          repeat (3) c = crc_step(c, 8'h00);
          r.hash = c;
          r.code = OUT_HASHED;
        end
      end else begin
        // ethertype never resolved
        r.code = OUT_TOO_SHORT;
      end
      pending_hashes.push_back(r);
      phase = PARSE_IDLE;
    endfunction

    function void match_result(logic [31:0] hash, logic [1:0] code);
      flow_result_t w;
      if (pending_hashes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, hash %h outcome %0d", $time, hash, code);
        return;
      end
      w = pending_hashes.pop_front();
      by_code[w.code]++;
      if (hash !== w.hash) begin
        errors++;
        $display("%0t: flow_hash expected %h actual %h", $time, w.hash, hash);
      end
      if (code !== w.code) begin
        errors++;
        $display("%0t: outcome expected %0d actual %0d", $time, w.code, code);
      end
    endfunction

    function int unsigned pending();
      return pending_hashes.size();
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tuser;   // [0] first_byte
  logic        s_axis_tlast;
  logic        m_axis_tvalid, m_axis_tready;
  logic [39:0] m_axis_tdata;   // [31:0] flow_hash, [33:32] outcome
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  flow_hash_tracker tracker = new();

  logic [7:0]  pkt[$];
  bit          cfg_raw = 1'b0;
  logic [15:0] cfg_tag_a = TagFirstReset;
  logic [15:0] cfg_tag_b = TagSecondReset;
  bit          src_idle_en = 1'b1;
  bit          snk_idle_en = 1'b1;
  int unsigned cycle_count = 0;
  int unsigned reg_writes = 0;

  crc32c_five_tuple_flow_hash_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("FAIL crc32c_five_tuple_flow_hash_unit");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.match_result(m_axis_tdata[31:0], m_axis_tdata[33:32]);
  end

  // result side backpressure
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (snk_idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(0, 15)) @(posedge clk_i);
    end
  end

  function automatic logic [7:0] filler(input int fill);
    return (fill < 0) ? 8'($urandom) : 8'(fill);
  endfunction

  task automatic wait_drained();
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, val);
    case (idx)
      RegEntryMode: cfg_raw = val[0];
      RegTagFirst:  cfg_tag_a = val[15:0];
      RegTagSecond: cfg_tag_b = val[15:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic send_beat(input logic [7:0] b, input bit first, input bit last);
    if (src_idle_en && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.take_beat(b, first, last);
  endtask

  task automatic send_packet(input bit lead, input bit close);
    for (int i = 0; i < pkt.size(); i++)
      send_beat(pkt[i], lead && i == 0, close && i == pkt.size() - 1);
  endtask

  task automatic trim_packet(input int n);
    while (pkt.size() > n) void'(pkt.pop_back());
  endtask

  // ethernet header (skipped in raw mode), ip header, then l4 bytes
  task automatic build_packet(input bit raw, input int ntags, input logic [15:0] etype,
                              input bit v6, input logic [3:0] ver, input logic [3:0] ihl,
                              input logic [7:0] proto, input int l4len, input int fill);
    logic [15:0] tag;
    logic [7:0]  low;
    int          hdr;
    pkt.delete();
    if (!raw) begin
      repeat (12) pkt.push_back(filler(fill));
      for (int t = 0; t < ntags; t++) begin
        tag = (t % 2) ? cfg_tag_b : cfg_tag_a;
        pkt.push_back(tag[15:8]);
        pkt.push_back(tag[7:0]);
        repeat (2) pkt.push_back(filler(fill));
      end
      pkt.push_back(etype[15:8]);
      pkt.push_back(etype[7:0]);
    end
    hdr = pkt.size();
    low = filler(fill);
    if (v6) begin
      pkt.push_back({ver, low[3:0]});
      repeat (39) pkt.push_back(filler(fill));
      pkt[hdr+6] = proto;
    end else begin
      pkt.push_back({ver, ihl});
      repeat (19) pkt.push_back(filler(fill));
      pkt[hdr+9] = proto;
      if (ihl > 5) repeat (4 * (ihl - 5)) pkt.push_back(filler(fill));
    end
    repeat (l4len) pkt.push_back(filler(fill));
  endtask

  task automatic build_random();
    int          r, ntags, l4len;
    bit          v6;
    logic [15:0] et;
    logic [3:0]  ver, ihl;
    logic [7:0]  proto;
    r = $urandom_range(0, 99);
    if (r < 7) begin
      pkt.delete();
      repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
      return;
    end
    r = $urandom_range(0, 9);
    ntags = (r < 5) ? 0 : (r < 8) ? $urandom_range(1, 2) : $urandom_range(3, 5);
    r = $urandom_range(0, 99);
    et = (r < 45) ? EtypeIpv4 : (r < 85) ? EtypeIpv6 : 16'($urandom);
    v6 = cfg_raw ? 1'($urandom_range(0, 1)) : (et == EtypeIpv6);
    ver = v6 ? 4'h6 : 4'h4;
    if ($urandom_range(0, 19) == 0) ver = 4'($urandom);
    ihl = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'd5;
    case ($urandom_range(0, 8))
      0: proto = ProtoTcp;
      1: proto = ProtoUdp;
      2: proto = ProtoEsp;
      3: proto = ProtoAh;
      4: proto = ProtoIcmp;
      5: proto = ProtoIcmpV6;
      6: proto = ProtoIgmp;
      7: proto = 8'($urandom);
      default: proto = ProtoTcp;
    endcase
    l4len = ($urandom_range(0, 9) != 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
    if ($urandom_range(0, 99) == 0) l4len = $urandom_range(250, 290);
    build_packet(cfg_raw, ntags, et, v6, ver, ihl, proto, l4len, -1);
    if ($urandom_range(0, 9) == 0) trim_packet($urandom_range(1, pkt.size()));
  endtask

  task automatic run_random(input int budget, input bit hold_once);
    int sent;
    bit held;
    bit cut;
    sent = 0;
    held = 1'b0;
    while (sent < budget) begin
      build_random();
      cut = ($urandom_range(0, 24) == 0);
      if (cut) trim_packet($urandom_range(1, pkt.size()));
      send_packet($urandom_range(0, 9) != 0, !cut);
      sent += pkt.size();
      if (hold_once && !held && sent >= budget / 2) begin
        held = 1'b1;
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        wait_drained();
      end
    end
    // close the phase on a whole packet so the parser is idle
    build_packet(cfg_raw, 0, EtypeIpv4, 1'b0, 4'h4, 4'd5, ProtoUdp, 4, -1);
    send_packet(1'b1, 1'b1);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ethernet entry, default tag types
    build_packet(0, 0, EtypeIpv4, 0, 4'h4, 4'd5, ProtoTcp, 4, 'hff);
    send_packet(1, 1);
    build_packet(0, 2, EtypeIpv4, 0, 4'h4, 4'd5, ProtoUdp, 8, 0);
    send_packet(1, 1);
    build_packet(0, 5, EtypeIpv4, 0, 4'h4, 4'd5, ProtoTcp, 4, -1);
    send_packet(1, 1);
    build_packet(0, 4, EtypeIpv6, 1, 4'h6, 4'd0, ProtoIcmpV6, 2, -1);
    send_packet(1, 1);
    build_packet(0, 0, 16'h0806, 0, 4'h4, 4'd5, ProtoTcp, 4, -1);
    send_packet(1, 1);
    build_packet(0, 0, EtypeIpv4, 0, 4'h4, 4'd5, ProtoTcp, 4, -1);
    trim_packet(10);
    send_packet(1, 1);
    build_packet(0, 0, EtypeIpv4, 0, 4'h4, 4'd5, ProtoTcp, 4, -1);
    trim_packet(30);
    send_packet(1, 1);
    // version nibble ignored behind an ipv4 ethertype
    build_packet(0, 0, EtypeIpv4, 0, 4'h6, 4'd5, ProtoUdp, 4, -1);
    send_packet(1, 1);
    // hop-by-hop next header is hashed with no l4 bytes
    build_packet(0, 0, EtypeIpv6, 1, 4'h6, 4'd0, 8'd0, 8, -1);
    send_packet(1, 1);
    build_packet(0, 0, EtypeIpv4, 0, 4'h4, 4'd2, ProtoTcp, 0, -1);
    send_packet(1, 1);
    build_packet(0, 0, EtypeIpv4, 0, 4'h4, 4'd5, ProtoIgmp, 1, -1);
    send_packet(1, 1);
    build_packet(0, 0, EtypeIpv4, 0, 4'h4, 4'd5, ProtoIcmp, 2, -1);
    send_packet(1, 1);
    build_packet(0, 0, EtypeIpv4, 0, 4'h4, 4'd5, 8'd255, 0, -1);
    send_packet(1, 1);
    build_packet(0, 0, EtypeIpv4, 0, 4'h4, 4'd5, ProtoTcp, 2, -1);
    send_packet(1, 1);
    pkt.delete();
    pkt.push_back(8'h45);
    send_packet(1, 1);
    // no first-byte flag on an idle parser
    build_packet(0, 0, EtypeIpv4, 0, 4'h4, 4'd5, ProtoUdp, 4, -1);
    send_packet(0, 1);
    // new first byte drops the open packet
    build_packet(0, 0, EtypeIpv4, 0, 4'h4, 4'd5, ProtoTcp, 4, -1);
    trim_packet(20);
    send_packet(1, 0);
    build_packet(0, 0, EtypeIpv4, 0, 4'h4, 4'd5, ProtoUdp, 4, -1);
    send_packet(1, 1);
    // long enough for the offset to saturate
    build_packet(0, 0, EtypeIpv4, 0, 4'h4, 4'd5, ProtoTcp, 280, -1);
    send_packet(1, 1);
    settle();

    write_reg(RegEntryMode, 32'd1);
    build_packet(1, 0, '0, 0, 4'h4, 4'd15, ProtoUdp, 4, -1);
    send_packet(1, 1);
    build_packet(1, 0, '0, 1, 4'h6, 4'd0, ProtoTcp, 4, -1);
    send_packet(1, 1);
    build_packet(1, 0, '0, 0, 4'h5, 4'd5, ProtoTcp, 4, -1);
    send_packet(1, 1);
    build_packet(1, 0, '0, 0, 4'h0, 4'd0, ProtoTcp, 4, 0);
    send_packet(1, 1);
    pkt.delete();
    pkt.push_back(8'h45);
    send_packet(1, 1);
    build_packet(1, 0, '0, 0, 4'h4, 4'd0, ProtoTcp, 0, -1);
    send_packet(1, 1);
    run_random(100, 1);
    settle();

    write_reg(RegEntryMode, 32'd0);
    write_reg(RegTagFirst, 32'h0000);
    write_reg(RegTagSecond, 32'hffff);
    run_random(70, 0);
    settle();

    write_reg(RegTagFirst, 32'(EtypeIpv6));
    write_reg(RegTagSecond, 32'h9100);
    run_random(50, 0);
    settle();

    write_reg(RegTagFirst, 32'(TagFirstReset));
    write_reg(RegTagSecond, 32'(TagSecondReset));
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    run_random(50, 0);
    settle();

    $display("covered %0d packet beats and %0d result beats over %0d register writes",
             tracker.beats, tracker.by_code[0] + tracker.by_code[1] + tracker.by_code[2]
             + tracker.by_code[3], reg_writes);
    $display("outcomes: %0d hashed, %0d not ip, %0d short, %0d too many tags",
             tracker.by_code[OUT_HASHED], tracker.by_code[OUT_NOT_IP],
             tracker.by_code[OUT_TOO_SHORT], tracker.by_code[OUT_MANY_TAGS]);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS crc32c_five_tuple_flow_hash_unit");
    end else begin
      $display("FAIL crc32c_five_tuple_flow_hash_unit");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/cfh_pkg.sv
rtl/core/crc32c_five_tuple_flow_hash_unit.sv
test/tb_crc32c_five_tuple_flow_hash_unit.sv
